[rtl/rsmp_pkg.sv]
// Shared types and constants of the bilinear image resampler.
// Used by every module of the block; depends on nothing.
package rsmp_pkg;

  localparam int DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT = 256;
  localparam int DEF_WEIGHT_BITS       = 8;

  localparam int COORD_W  = 12;  // column, line and store coordinates
  localparam int SRC_SZ_W = 9;   // source size registers
  localparam int TGT_SZ_W = 13;  // target size registers
  localparam int CFG_W    = 13;  // widest register
  localparam int WMAX_W   = 16;  // storage for a weight of up to sixteen bits
  localparam int DIV_STEPS = 8;  // quotient bits per clock in the mapper
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;

  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TGT_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_TGT_HEIGHT = 2'd3;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Read slots of one compute transaction, in issue order.
  localparam logic [1:0] RD_P00 = 2'd0;
  localparam logic [1:0] RD_P10 = 2'd1;
  localparam logic [1:0] RD_P11 = 2'd2;
  localparam logic [1:0] RD_P01 = 2'd3;

  typedef struct packed {
    logic               is_write;
    logic               wr_ok;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [WMAX_W-1:0]  u;
    logic [WMAX_W-1:0]  v;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic [23:0]        rgb;
  } entry_t;

endpackage

[rtl/bilinear_image_resampler.sv]
// Top level of the bilinear image resampler: configuration registers and
// the front end, queue and back end. Depends on rsmp_pkg, rsmp_front, rsmp_queue, rsmp_back.
//
//   channel   direction  handshake              contents
//   command   in         start, busy            opcode, column, line, in_red/green/blue
//   result    out        done (one cycle)       out_red/green/blue, out_column, out_line
//   config    in         cfg_write              cfg_index, cfg_data
//
// A compute transaction is paced by the four neighbor reads through the single
// port of the frame store, and the mapping divider is matched to them at eight
// quotient bits a clock. Reset (rst, synchronous) empties the pipeline and sets
// all four sizes to 256; the frame store is not cleared. busy stalls commands
// only; results cannot be held off.
module bilinear_image_resampler #(
  parameter int MAX_SOURCE_WIDTH  = rsmp_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = rsmp_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int WEIGHT_BITS       = rsmp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [rsmp_pkg::COORD_W-1:0] column,
  input  logic [rsmp_pkg::COORD_W-1:0] line,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [rsmp_pkg::CFG_W-1:0]   cfg_data,
  output logic                         done,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic [rsmp_pkg::COORD_W-1:0] out_column,
  output logic [rsmp_pkg::COORD_W-1:0] out_line
);
  logic [rsmp_pkg::SRC_SZ_W-1:0] source_width, source_height;
  logic [rsmp_pkg::TGT_SZ_W-1:0] target_width, target_height;

  // Config registers; the user issues writes only while the block is idle, unenforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= rsmp_pkg::SRC_SZ_W'(256);
      source_height <= rsmp_pkg::SRC_SZ_W'(256);
      target_width  <= rsmp_pkg::TGT_SZ_W'(256);
      target_height <= rsmp_pkg::TGT_SZ_W'(256);
    end else if (cfg_write) begin
      case (cfg_index)
        rsmp_pkg::CFG_SRC_WIDTH:  source_width  <= cfg_data[rsmp_pkg::SRC_SZ_W-1:0];
        rsmp_pkg::CFG_SRC_HEIGHT: source_height <= cfg_data[rsmp_pkg::SRC_SZ_W-1:0];
        rsmp_pkg::CFG_TGT_WIDTH:  target_width  <= cfg_data;
        rsmp_pkg::CFG_TGT_HEIGHT: target_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             q_full, q_empty, push, pop;
  rsmp_pkg::entry_t push_entry, head;

  // The front end maps and classifies each compute transaction, then queues every transaction.
  rsmp_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT),
    .WEIGHT_BITS      (WEIGHT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .column       (column),
    .line         (line),
    .rgb          ({in_red, in_green, in_blue}),
    .source_width (source_width),
    .source_height(source_height),
    .target_width (target_width),
    .target_height(target_height),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Writes and computes share the queue, so a read always sees every
  // earlier write in order.
  rsmp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  rsmp_back #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT),
    .WEIGHT_BITS      (WEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_column(out_column),
    .out_line  (out_line)
  );

endmodule

[rtl/rsmp_front.sv]
// Front end: accepts transactions, maps compute pixels to source positions
// with a radix-256 divider and classifies edges. Depends on rsmp_pkg.
module rsmp_front #(
  parameter int MAX_SOURCE_WIDTH  = rsmp_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = rsmp_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int WEIGHT_BITS       = rsmp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             opcode,
  input  logic [rsmp_pkg::COORD_W-1:0]     column,
  input  logic [rsmp_pkg::COORD_W-1:0]     line,
  input  logic [23:0]                      rgb,
  input  logic [rsmp_pkg::SRC_SZ_W-1:0]    source_width,
  input  logic [rsmp_pkg::SRC_SZ_W-1:0]    source_height,
  input  logic [rsmp_pkg::TGT_SZ_W-1:0]    target_width,
  input  logic [rsmp_pkg::TGT_SZ_W-1:0]    target_height,
  input  logic                             q_full,
  output logic                             push,
  output rsmp_pkg::entry_t                 push_entry
);
  localparam int NUM_W = rsmp_pkg::TGT_SZ_W + rsmp_pkg::SRC_SZ_W + 1;
  localparam int NCYC  = (NUM_W + WEIGHT_BITS + rsmp_pkg::DIV_STEPS - 1) / rsmp_pkg::DIV_STEPS;
  localparam int QW    = NCYC * rsmp_pkg::DIV_STEPS;
  localparam int IPW   = QW - WEIGHT_BITS;
  localparam int DEN_W = rsmp_pkg::TGT_SZ_W + 1;
  localparam int CW    = (NCYC > 1) ? $clog2(NCYC) : 1;

  logic [rsmp_pkg::SRC_SZ_W-1:0] sw, sh;
  logic [rsmp_pkg::TGT_SZ_W-1:0] tw, th;

  always_comb begin
    sw = (source_width == '0) ? rsmp_pkg::SRC_SZ_W'(1) :
         (32'(source_width) > 32'(MAX_SOURCE_WIDTH)) ?
           rsmp_pkg::SRC_SZ_W'(MAX_SOURCE_WIDTH) : source_width;
    sh = (source_height == '0) ? rsmp_pkg::SRC_SZ_W'(1) :
         (32'(source_height) > 32'(MAX_SOURCE_HEIGHT)) ?
           rsmp_pkg::SRC_SZ_W'(MAX_SOURCE_HEIGHT) : source_height;
    tw = (target_width == '0) ? rsmp_pkg::TGT_SZ_W'(1) : target_width;
    th = (target_height == '0) ? rsmp_pkg::TGT_SZ_W'(1) : target_height;
  end

  // Working slot: one transaction being mapped.
  logic                         slot_valid, slot_write, slot_wr_ok;
  logic [CW-1:0]                slot_cnt;
  logic [rsmp_pkg::COORD_W-1:0] slot_col, slot_line;
  logic [23:0]                  slot_rgb;
  logic [DEN_W-1:0]             den_x, den_y, rem_x, rem_y;
  logic [QW-1:0]                dq_x, dq_y;

  // Finished transaction waiting for room in the queue.
  logic                         pend_valid, pend_write, pend_wr_ok;
  logic [rsmp_pkg::COORD_W-1:0] pend_col, pend_line;
  logic [23:0]                  pend_rgb;
  logic [QW-1:0]                pend_qx, pend_qy;

  logic accept, slot_last, pend_free, done_move;

  assign slot_last = slot_write || (slot_cnt == CW'(NCYC - 1));
  assign push      = pend_valid && !q_full;
  assign pend_free = !pend_valid || !q_full;
  assign done_move = slot_valid && slot_last && pend_free;
  assign busy      = slot_valid && !done_move;
  assign accept    = start && !busy;

  // Eight restoring division steps per clock on each axis.
  logic [DEN_W-1:0] rx, ry;
  logic [QW-1:0]    qx, qy;
  logic [DEN_W:0]   shx, shy;

  always_comb begin
    rx = rem_x;
    ry = rem_y;
    qx = dq_x;
    qy = dq_y;
    shx = '0;
    shy = '0;
    for (int i = 0; i < rsmp_pkg::DIV_STEPS; i++) begin
      shx = {rx, qx[QW-1]};
      shy = {ry, qy[QW-1]};
      qx = {qx[QW-2:0], 1'b0};
      qy = {qy[QW-2:0], 1'b0};
      if (shx >= {1'b0, den_x}) begin
        rx = DEN_W'(shx - {1'b0, den_x});
        qx[0] = 1'b1;
      end else begin
        rx = shx[DEN_W-1:0];
      end
      if (shy >= {1'b0, den_y}) begin
        ry = DEN_W'(shy - {1'b0, den_y});
        qy[0] = 1'b1;
      end else begin
        ry = shy[DEN_W-1:0];
      end
    end
  end

  // Dividends are offset by one whole divisor so they stay non-negative.
  logic [NUM_W-1:0] num_x, num_y;
  assign num_x = NUM_W'({column, 1'b1}) * NUM_W'(sw) + NUM_W'(tw);
  assign num_y = NUM_W'({line, 1'b1}) * NUM_W'(sh) + NUM_W'(th);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        slot_valid <= 1'b1;
      end else if (done_move) begin
        slot_valid <= 1'b0;
      end
      if (done_move) begin
        pend_valid <= 1'b1;
      end else if (push) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_write <= (opcode == rsmp_pkg::OP_WRITE);
      slot_wr_ok <= (32'(column) < 32'(MAX_SOURCE_WIDTH)) &&
                    (32'(line) < 32'(MAX_SOURCE_HEIGHT));
      slot_cnt   <= '0;
      slot_col   <= column;
      slot_line  <= line;
      slot_rgb   <= rgb;
      den_x      <= {tw, 1'b0};
      den_y      <= {th, 1'b0};
      rem_x      <= '0;
      rem_y      <= '0;
      dq_x       <= QW'({num_x, WEIGHT_BITS'(0)});
      dq_y       <= QW'({num_y, WEIGHT_BITS'(0)});
    end else if (slot_valid && !slot_last) begin
      slot_cnt <= slot_cnt + CW'(1);
      rem_x    <= rx;
      rem_y    <= ry;
      dq_x     <= qx;
      dq_y     <= qy;
    end
    if (done_move) begin
      pend_write <= slot_write;
      pend_wr_ok <= slot_wr_ok;
      pend_col   <= slot_col;
      pend_line  <= slot_line;
      pend_rgb   <= slot_rgb;
      pend_qx    <= qx;
      pend_qy    <= qy;
    end
  end

  // Edge classification: the integer part carries an offset of one, so zero
  // means before the first pixel and a value of at least the size means on
  // or past the last pixel; both clamp and drop the weight on that axis.
  logic [IPW-1:0] ipx, ipy;
  assign ipx = pend_qx[QW-1:WEIGHT_BITS];
  assign ipy = pend_qy[QW-1:WEIGHT_BITS];

  always_comb begin
    push_entry          = '0;
    push_entry.is_write = pend_write;
    push_entry.wr_ok    = pend_wr_ok;
    push_entry.column   = pend_col;
    push_entry.line     = pend_line;
    push_entry.rgb      = pend_rgb;
    if (pend_write) begin
      push_entry.x0 = pend_col;
      push_entry.y0 = pend_line;
    end else begin
      if (ipx == '0) begin
        push_entry.x0 = '0;
        push_entry.x1 = '0;
      end else if (ipx >= IPW'(sw)) begin
        push_entry.x0 = rsmp_pkg::COORD_W'(sw - rsmp_pkg::SRC_SZ_W'(1));
        push_entry.x1 = push_entry.x0;
      end else begin
        push_entry.x0 = rsmp_pkg::COORD_W'(ipx - IPW'(1));
        push_entry.x1 = rsmp_pkg::COORD_W'(ipx);
        push_entry.u  = rsmp_pkg::WMAX_W'(pend_qx[WEIGHT_BITS-1:0]);
      end
      if (ipy == '0) begin
        push_entry.y0 = '0;
        push_entry.y1 = '0;
      end else if (ipy >= IPW'(sh)) begin
        push_entry.y0 = rsmp_pkg::COORD_W'(sh - rsmp_pkg::SRC_SZ_W'(1));
        push_entry.y1 = push_entry.y0;
      end else begin
        push_entry.y0 = rsmp_pkg::COORD_W'(ipy - IPW'(1));
        push_entry.y1 = rsmp_pkg::COORD_W'(ipy);
        push_entry.v  = rsmp_pkg::WMAX_W'(pend_qy[WEIGHT_BITS-1:0]);
      end
    end
  end

endmodule

[rtl/rsmp_queue.sv]
// Short FIFO of classified transactions between front and back end.
// Depends on rsmp_pkg.
module rsmp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rsmp_pkg::entry_t push_entry,
  input  logic             pop,
  output rsmp_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  rsmp_pkg::entry_t               slots [rsmp_pkg::Q_DEPTH];
  logic [rsmp_pkg::Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [rsmp_pkg::Q_PTR_W:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (rsmp_pkg::Q_PTR_W + 1)'(rsmp_pkg::Q_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/rsmp_back.sv]
// Back end: owns the single-port frame store, performs writes, issues the
// four neighbor reads of a compute and runs the two-stage blend. Depends on rsmp_pkg.
module rsmp_back #(
  parameter int MAX_SOURCE_WIDTH  = rsmp_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = rsmp_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int WEIGHT_BITS       = rsmp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rsmp_pkg::entry_t              head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          done,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [rsmp_pkg::COORD_W-1:0]  out_column,
  output logic [rsmp_pkg::COORD_W-1:0]  out_line
);
  localparam int DEPTH  = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int H_W    = 8 + WEIGHT_BITS;
  localparam int SUM_W  = 8 + 2 * WEIGHT_BITS;
  localparam int S_W    = WEIGHT_BITS + 1;

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data;

  logic             active;
  logic [1:0]       cnt;
  rsmp_pkg::entry_t cur;
  logic             pop_write, pop_comp, we;
  logic [ADDR_W-1:0] addr;
  logic [rsmp_pkg::COORD_W-1:0] rx, ry;

  assign pop_write = !empty && head.is_write && !active;
  assign pop_comp  = !empty && !head.is_write && (!active || cnt == rsmp_pkg::RD_P01);
  assign pop       = pop_write || pop_comp;
  assign we        = pop_write && head.wr_ok;

  always_comb begin
    case (cnt)
      rsmp_pkg::RD_P00: begin rx = cur.x0; ry = cur.y0; end
      rsmp_pkg::RD_P10: begin rx = cur.x1; ry = cur.y0; end
      rsmp_pkg::RD_P11: begin rx = cur.x1; ry = cur.y1; end
      rsmp_pkg::RD_P01: begin rx = cur.x0; ry = cur.y1; end
      default:          begin rx = cur.x0; ry = cur.y0; end
    endcase
    if (we) begin
      addr = ADDR_W'(32'(head.y0) * MAX_SOURCE_WIDTH + 32'(head.x0));
    end else begin
      addr = ADDR_W'(32'(ry) * MAX_SOURCE_WIDTH + 32'(rx));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= head.rgb;
    end else begin
      rd_data <= mem[addr];
    end
  end

  // Read sequencer and the read-data capture.
  logic                          rd_v, s1_v;
  logic [1:0]                    rd_slot;
  logic [23:0]                   p00, p10, p11;
  logic [WEIGHT_BITS-1:0]        mu, mv, s1_v_w;
  logic [rsmp_pkg::COORD_W-1:0]  mcol, mline, s1_col, s1_line;
  logic [H_W-1:0]                h0 [3];
  logic [H_W-1:0]                h1 [3];
  logic [H_W-1:0]                h0_n [3];
  logic [H_W-1:0]                h1_n [3];
  logic [SUM_W-1:0]              sum_n [3];
  logic [S_W-1:0]                su, sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= rsmp_pkg::RD_P00;
      rd_v   <= 1'b0;
      s1_v   <= 1'b0;
      done   <= 1'b0;
    end else begin
      if (pop_comp) begin
        active <= 1'b1;
        cnt    <= rsmp_pkg::RD_P00;
      end else if (active && cnt == rsmp_pkg::RD_P01) begin
        active <= 1'b0;
      end else if (active) begin
        cnt <= cnt + 2'd1;
      end
      rd_v <= active;
      s1_v <= rd_v && (rd_slot == rsmp_pkg::RD_P01);
      done <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_comp) begin
      cur <= head;
    end
    rd_slot <= cnt;
    if (active && cnt == rsmp_pkg::RD_P01) begin
      mu    <= cur.u[WEIGHT_BITS-1:0];
      mv    <= cur.v[WEIGHT_BITS-1:0];
      mcol  <= cur.column;
      mline <= cur.line;
    end
    if (rd_v) begin
      case (rd_slot)
        rsmp_pkg::RD_P00: p00 <= rd_data;
        rsmp_pkg::RD_P10: p10 <= rd_data;
        rsmp_pkg::RD_P11: p11 <= rd_data;
        default: ;
      endcase
    end
  end

  // Horizontal blend of both rows, then the vertical blend; truncation
  // happens only once, at the end.
  assign su = S_W'(1 << WEIGHT_BITS) - S_W'(mu);
  assign sv = S_W'(1 << WEIGHT_BITS) - S_W'(s1_v_w);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      h0_n[c] = H_W'(p00[c*8 +: 8]) * H_W'(su) + H_W'(p10[c*8 +: 8]) * H_W'(mu);
      h1_n[c] = H_W'(rd_data[c*8 +: 8]) * H_W'(su) + H_W'(p11[c*8 +: 8]) * H_W'(mu);
      sum_n[c] = SUM_W'(h0[c]) * SUM_W'(sv) + SUM_W'(h1[c]) * SUM_W'(s1_v_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v && rd_slot == rsmp_pkg::RD_P01) begin
      for (int c = 0; c < 3; c++) begin
        h0[c] <= h0_n[c];
        h1[c] <= h1_n[c];
      end
      s1_v_w  <= mv;
      s1_col  <= mcol;
      s1_line <= mline;
    end
    if (s1_v) begin
      out_blue   <= sum_n[0][SUM_W-1 -: 8];
      out_green  <= sum_n[1][SUM_W-1 -: 8];
      out_red    <= sum_n[2][SUM_W-1 -: 8];
      out_column <= s1_col;
      out_line   <= s1_line;
    end
  end

endmodule

[tb/bilinear_image_resampler_tb.sv]
// Self-checking testbench of the bilinear image resampler: directed and random
// write and compute transactions against an in-bench predictor of the block.
// Depends on rsmp_pkg and the bilinear_image_resampler RTL.
`timescale 1ns / 1ps

module bilinear_image_resampler_tb;
  import rsmp_pkg::*;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int WB = 8;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = OP_WRITE;
  logic [COORD_W-1:0] column = '0;
  logic [COORD_W-1:0] line = '0;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_SRC_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic done;
  logic [7:0] out_red, out_green, out_blue;
  logic [COORD_W-1:0] out_column, out_line;

  // Predictor state: a copy of the frame store, a written-flag per pixel so
  // that computes only ever touch pixels that hold data, and the size registers.
  logic [23:0] frame_copy [MAXW*MAXH];
  bit written [MAXW*MAXH];
  logic [SRC_SZ_W-1:0] src_w_reg, src_h_reg;
  logic [TGT_SZ_W-1:0] tgt_w_reg, tgt_h_reg;

  pixel_result_t pending_pixels[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bilinear_image_resampler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .column(column), .line(line), .in_red(in_red), .in_green(in_green),
    .in_blue(in_blue), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_column(out_column), .out_line(out_line)
  );

  // Watchdog: any cycle without an accepted command or result counts toward
  // the stall limit; the slowest legal gap is far below it.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                 pending_pixels.size());
        $display("bilinear_image_resampler_tb: done, errors");
        $finish;
      end
    end
  end

  // Result checker: every done pulse is matched with the oldest prediction.
  always @(posedge clk) begin
    pixel_result_t exp_px;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result col %0d line %0d rgb %h%h%h", $realtime,
                 out_column, out_line, out_red, out_green, out_blue);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_red !== exp_px.red || out_green !== exp_px.green ||
            out_blue !== exp_px.blue || out_column !== exp_px.column ||
            out_line !== exp_px.line) begin
          $display("%0t: mismatch expected col %0d line %0d rgb %h%h%h, got col %0d line %0d rgb %h%h%h",
                   $realtime, exp_px.column, exp_px.line, exp_px.red, exp_px.green,
                   exp_px.blue, out_column, out_line, out_red, out_green, out_blue);
          errors++;
        end
      end
    end
  end

  function automatic longint eff_dim(longint v, longint maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Floor-divides the source position of one destination coordinate and
  // returns the integer part with the WB-bit fraction.
  function automatic void source_position(longint pos, longint src, longint dst,
                                          output longint ipart, output longint frac);
    longint num, den, q, r;
    num = (2 * pos + 1) * src - dst;
    den = 2 * dst;
    q = num / den;
    r = num % den;
    if (r < 0) begin
      q -= 1;
      r += den;
    end
    ipart = q;
    frac = (r << WB) / den;
  endfunction

  function automatic logic [23:0] stored_pixel(longint x, longint y);
    if (x < 0 || y < 0 || x >= MAXW || y >= MAXH) return '0;
    return frame_copy[y * MAXW + x];
  endfunction

  function automatic logic [23:0] edge_blend(longint w, logic [23:0] a, logic [23:0] b);
    logic [23:0] res;
    longint s;
    s = 1 << WB;
    for (int sh = 0; sh < 24; sh += 8)
      res[sh +: 8] = 8'((longint'(a[sh +: 8]) * (s - w) + longint'(b[sh +: 8]) * w) >> WB);
    return res;
  endfunction

  function automatic logic [23:0] area_blend(longint u, longint v, logic [23:0] p00,
                                             logic [23:0] p10, logic [23:0] p11,
                                             logic [23:0] p01);
    logic [23:0] res;
    longint s, sum;
    s = 1 << WB;
    for (int sh = 0; sh < 24; sh += 8) begin
      sum = longint'(p00[sh +: 8]) * (s - u) * (s - v) + longint'(p10[sh +: 8]) * u * (s - v)
          + longint'(p11[sh +: 8]) * u * v + longint'(p01[sh +: 8]) * (s - u) * v;
      res[sh +: 8] = 8'(sum >> (2 * WB));
    end
    return res;
  endfunction

  // Works out the pixel a compute transaction must return.
  function automatic logic [23:0] resampled_pixel(logic [COORD_W-1:0] col,
                                                  logic [COORD_W-1:0] row);
    longint sw, sh, tw, th, xi, yi, u, v;
    sw = eff_dim(src_w_reg, MAXW);
    sh = eff_dim(src_h_reg, MAXH);
    tw = eff_dim(tgt_w_reg, 8191);
    th = eff_dim(tgt_h_reg, 8191);
    source_position(col, sw, tw, xi, u);
    source_position(row, sh, th, yi, v);
    // Corners first, then edge rows, then edge columns, then the interior.
    if (yi < 0 && xi < 0) return stored_pixel(0, 0);
    if (yi < 0 && xi >= sw - 1) return stored_pixel(sw - 1, 0);
    if (yi >= sh - 1 && xi >= sw - 1) return stored_pixel(sw - 1, sh - 1);
    if (yi >= sh - 1 && xi < 0) return stored_pixel(0, sh - 1);
    if (yi < 0) return edge_blend(u, stored_pixel(xi, 0), stored_pixel(xi + 1, 0));
    if (yi >= sh - 1)
      return edge_blend(u, stored_pixel(xi, sh - 1), stored_pixel(xi + 1, sh - 1));
    if (xi < 0) return edge_blend(v, stored_pixel(0, yi), stored_pixel(0, yi + 1));
    if (xi >= sw - 1)
      return edge_blend(v, stored_pixel(sw - 1, yi), stored_pixel(sw - 1, yi + 1));
    return area_blend(u, v, stored_pixel(xi, yi), stored_pixel(xi + 1, yi),
                      stored_pixel(xi + 1, yi + 1), stored_pixel(xi, yi + 1));
  endfunction

  // Sends one command transaction, with an occasional random gap in front of
  // it unless no_gaps is set, and updates the predictor once the block has taken it.
  task automatic send_command(logic op, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              logic [23:0] rgb);
    pixel_result_t exp_px;
    logic [23:0] px;
    if (!no_gaps) begin
      while ($urandom_range(99) < 8) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    opcode <= op;
    column <= col;
    line <= row;
    in_red <= rgb[23:16];
    in_green <= rgb[15:8];
    in_blue <= rgb[7:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_WRITE) begin
      if (col < MAXW && row < MAXH) begin
        frame_copy[row * MAXW + col] = rgb;
        written[row * MAXW + col] = 1'b1;
      end
    end else begin
      px = resampled_pixel(col, row);
      exp_px.red = px[23:16];
      exp_px.green = px[15:8];
      exp_px.blue = px[7:0];
      exp_px.column = col;
      exp_px.line = row;
      pending_pixels.push_back(exp_px);
    end
  endtask

  // Holds commands off until every outstanding result has come back, then
  // lets the block drain any trailing write.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic write_size(logic [1:0] idx, logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH: src_w_reg = value[SRC_SZ_W-1:0];
      CFG_SRC_HEIGHT: src_h_reg = value[SRC_SZ_W-1:0];
      CFG_TGT_WIDTH: tgt_w_reg = value[TGT_SZ_W-1:0];
      default: tgt_h_reg = value[TGT_SZ_W-1:0];
    endcase
  endtask

  task automatic set_sizes(int sw, int sh, int tw, int th);
    drain_results();
    write_size(CFG_SRC_WIDTH, CFG_W'(sw));
    write_size(CFG_SRC_HEIGHT, CFG_W'(sh));
    write_size(CFG_TGT_WIDTH, CFG_W'(tw));
    write_size(CFG_TGT_HEIGHT, CFG_W'(th));
  endtask

  // Writes every pixel of the w by h region at the origin of the store, so
  // that computes inside that region never touch an unwritten store entry.
  task automatic fill_source(int w, int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        send_command(OP_WRITE, COORD_W'(x), COORD_W'(y), 24'($urandom));
  endtask

  // True if the footprint the predictor may read for the current registers is written.
  function automatic bit area_written();
    longint sw, sh;
    sw = eff_dim(src_w_reg, MAXW);
    sh = eff_dim(src_h_reg, MAXH);
    for (longint y = 0; y < sh; y++)
      for (longint x = 0; x < sw; x++)
        if (!written[y * MAXW + x]) return 1'b0;
    return 1'b1;
  endfunction

  // Directed: extreme channels, extreme coordinates, corners, edges, a
  // destination outside the target, and ignored out-of-store writes.
  task automatic test_directed();
    set_sizes(4, 3, 9, 7);
    fill_source(4, 3);
    send_command(OP_WRITE, 12'd0, 12'd0, 24'hFFFFFF);
    send_command(OP_WRITE, 12'd3, 12'd2, 24'h000000);
    send_command(OP_WRITE, 12'd4095, 12'd4095, 24'hA5A5A5);
    send_command(OP_WRITE, 12'd256, 12'd1, 24'h123456);
    send_command(OP_WRITE, 12'd1, 12'd256, 24'h654321);
    send_command(OP_COMPUTE, 12'd0, 12'd0, 24'h0);
    send_command(OP_COMPUTE, 12'd8, 12'd0, 24'h0);
    send_command(OP_COMPUTE, 12'd8, 12'd6, 24'h0);
    send_command(OP_COMPUTE, 12'd0, 12'd6, 24'h0);
    send_command(OP_COMPUTE, 12'd4, 12'd0, 24'h0);
    send_command(OP_COMPUTE, 12'd4, 12'd6, 24'h0);
    send_command(OP_COMPUTE, 12'd0, 12'd3, 24'h0);
    send_command(OP_COMPUTE, 12'd8, 12'd3, 24'h0);
    send_command(OP_COMPUTE, 12'd4, 12'd3, 24'h0);
    send_command(OP_COMPUTE, 12'd4095, 12'd4095, 24'hFFFFFF);
    send_command(OP_COMPUTE, 12'd2730, 12'd1365, 24'h0);
  endtask

  // Register extremes: zero sizes act as one, oversized sources saturate,
  // and the largest targets are reached. With the largest targets the
  // chosen destinations only reach the top-left eight by eight pixels.
  task automatic test_size_extremes();
    set_sizes(0, 0, 0, 0);
    send_command(OP_COMPUTE, 12'd0, 12'd0, 24'h0);
    send_command(OP_COMPUTE, 12'd4095, 12'd17, 24'h0);
    set_sizes(1, 1, 4096, 4096);
    send_command(OP_COMPUTE, 12'd2048, 12'd4095, 24'h0);
    set_sizes(511, 511, 8191, 8191);
    fill_source(8, 8);
    send_command(OP_COMPUTE, 12'd0, 12'd0, 24'h0);
    send_command(OP_COMPUTE, 12'd200, 12'd200, 24'h0);
    send_command(OP_COMPUTE, 12'd100, 12'd60, 24'h0);
    set_sizes(8, 8, 1, 1);
    send_command(OP_COMPUTE, 12'd0, 12'd0, 24'h0);
    send_command(OP_COMPUTE, 12'd1, 12'd2, 24'h0);
  endtask

  // Random traffic: mostly computes within the target, some beyond it, and
  // writes to random coordinates, with a stretch that sends without gaps.
  task automatic test_random(int count);
    int sw, sh, tw, th;
    for (int phase = 0; phase < 5; phase++) begin
      sw = $urandom_range(1, 10);
      sh = $urandom_range(1, 10);
      tw = (phase == 4) ? $urandom_range(2000, 4096) : $urandom_range(1, 600);
      th = $urandom_range(1, 600);
      set_sizes(sw, sh, tw, th);
      if (!area_written()) fill_source(sw, sh);
      no_gaps = (phase == 2);
      for (int i = 0; i < count / 5; i++) begin
        case ($urandom_range(9))
          0, 1: send_command(OP_WRITE, COORD_W'($urandom), COORD_W'($urandom),
                             24'($urandom));
          2: send_command(OP_COMPUTE, COORD_W'($urandom), COORD_W'($urandom),
                          24'($urandom));
          default: send_command(OP_COMPUTE, COORD_W'($urandom_range(tw - 1)),
                                COORD_W'($urandom_range(th - 1)), 24'($urandom));
        endcase
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < MAXW * MAXH; i++) begin
      frame_copy[i] = '0;
      written[i] = 1'b0;
    end
    src_w_reg = 9'd256;
    src_h_reg = 9'd256;
    tgt_w_reg = 13'd256;
    tgt_h_reg = 13'd256;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_size_extremes();
    test_random(750);
    drain_results();
    if (errors == 0) begin
      $display("bilinear_image_resampler_tb: done, clean");
    end else begin
      $display("bilinear_image_resampler_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rsmp_pkg.sv
rtl/rsmp_front.sv
rtl/rsmp_queue.sv
rtl/rsmp_back.sv
rtl/bilinear_image_resampler.sv
tb/bilinear_image_resampler_tb.sv
